// ----- rtl/core/msd_pkg.sv -----
// ----------------------------------------------------------------------------
// msd_pkg - shared types and constants for the moving standard deviation
// Payload structs, arithmetic widths and controller/datapath interface.
// ----------------------------------------------------------------------------
package msd_pkg;

  // fixed payload widths
  localparam int SAMPLE_BITS = 24;
  localparam int WIN_BITS    = 7;
  localparam int DEV_BITS    = 31;

  // defaults for the top-level parameters
  localparam int WINDOW_MAX_DEF = 64;
  localparam int FRAC_BITS_DEF  = 8;

  // running sum, running sum of squares, and W*S2 - S1^2
  localparam int S1_W = SAMPLE_BITS + WIN_BITS;
  localparam int S2_W = 2 * SAMPLE_BITS - 1 + WIN_BITS;
  localparam int D_W  = 2 * (SAMPLE_BITS + WIN_BITS) - 1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          start_series;
  } in_item_t;

  typedef struct packed {
    logic [DEV_BITS-1:0] deviation;
    logic                deviation_valid;
  } out_item_t;

  typedef struct packed {
    logic capture;      // take the input item
    logic load_old;     // latch evicted sample, write new one
    logic update;       // advance sums, fill count and pointer
    logic mult;         // form W*S2 and S1^2
    logic diff_load;    // subtract and seed the square root
    logic sqrt_step;    // one root bit
    logic div_load;     // seed the divide by W
    logic div_step;     // one quotient bit
    logic result_load;  // write the output register
  } msd_cmd_t;

  typedef struct packed {
    logic window_full;  // fill count has reached the window length
    logic out_busy;     // output register holds an untaken result
  } msd_status_t;

endpackage

// ----- rtl/core/moving_std_deviation.sv -----
// ----------------------------------------------------------------------------
// moving_std_deviation - rolling population standard deviation
// Standard deviation of the last W samples with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
//  channel  | signals                      | transfer
//  ---------+------------------------------+---------------------------
//  input    | in_valid, in_ready, in_data  | in_valid && in_ready
//  output   | out_valid, out_ready, out_data | out_valid && out_ready
//  config   | cfg_we, cfg_wdata            | cfg_we
//
//  One item at a time: an item holds the input until its result is loaded into
//  the output register. With a full window it runs through the bit-serial square
//  root and the bit-serial divide by W, R = (D_W + 2*FRAC_BITS + 1) / 2 = 39 root
//  bits at FRAC_BITS = 8; while the window fills both are skipped. Reset is
//  synchronous and sets W = 1 with empty history. A stalled output holds its
//  result while the next item is already accepted and worked on.
// ----------------------------------------------------------------------------
module moving_std_deviation import msd_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [WIN_BITS-1:0] cfg_wdata
);

  msd_cmd_t    cmd;
  msd_status_t status;

  msd_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  msd_datapath #(
    .WINDOW_MAX (WINDOW_MAX),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // one item in flight: ready drops right after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |-> !(out_valid && !out_ready))
    else $error("output register overwritten");

  // a result that is not valid carries zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.deviation_valid |-> out_data.deviation == '0)
    else $error("invalid result with nonzero deviation");

  // root and divide never run together
  a_serial_units: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.sqrt_step, cmd.div_step, cmd.diff_load, cmd.div_load}))
    else $error("square root and divide overlap");

endmodule

// ----- rtl/core/msd_ram.sv -----
// ----------------------------------------------------------------------------
// msd_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module msd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/msd_ctrl.sv -----
// ----------------------------------------------------------------------------
// msd_ctrl - sequencer for the moving standard deviation
// Steps one item through history update, products, root and divide.
// ----------------------------------------------------------------------------
module msd_ctrl import msd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output msd_cmd_t    cmd,
  input  msd_status_t status
);

  localparam int R_W   = (D_W + 2 * FRAC_BITS + 1) / 2;
  localparam int CNT_W = $clog2(R_W);

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_OLD,
    S_UPDATE,
    S_MUL,
    S_DIFF,
    S_SQRT,
    S_DIVLOAD,
    S_DIV,
    S_DONE
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd             = '0;
    cmd.capture     = in_ready && in_valid;
    cmd.load_old    = (state == S_OLD);
    cmd.update      = (state == S_UPDATE);
    cmd.mult        = (state == S_MUL);
    cmd.diff_load   = (state == S_DIFF);
    cmd.sqrt_step   = (state == S_SQRT);
    cmd.div_load    = (state == S_DIVLOAD);
    cmd.div_step    = (state == S_DIV);
    cmd.result_load = (state == S_DONE) && !status.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_READ;
          end
        end
        S_READ:   state <= S_OLD;
        S_OLD:    state <= S_UPDATE;
        S_UPDATE: state <= S_MUL;
        S_MUL: begin
          // skip the arithmetic while the window is still filling
          state <= status.window_full ? S_DIFF : S_DONE;
        end
        S_DIFF: begin
          state <= S_SQRT;
          cnt   <= CNT_W'(R_W - 1);
        end
        S_SQRT: begin
          if (cnt == '0) begin
            state <= S_DIVLOAD;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_DIVLOAD: begin
          state <= S_DIV;
          cnt   <= CNT_W'(R_W - 1);
        end
        S_DIV: begin
          if (cnt == '0) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_DONE: begin
          if (!status.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/msd_datapath.sv -----
// ----------------------------------------------------------------------------
// msd_datapath - history, running sums, square root and divide
// Holds the window register, sample history RAM, sums and output register.
// ----------------------------------------------------------------------------
module msd_datapath import msd_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  in_item_t            in_data,
  input  logic                cfg_we,
  input  logic [WIN_BITS-1:0] cfg_wdata,
  input  msd_cmd_t            cmd,
  output msd_status_t         status,
  input  logic                out_ready,
  output logic                out_valid,
  output out_item_t           out_data
);

  localparam int PTR_W = $clog2(WINDOW_MAX);
  localparam int AW    = ((PTR_W > WIN_BITS) ? PTR_W : WIN_BITS) + 1;
  localparam int R_W   = (D_W + 2 * FRAC_BITS + 1) / 2;
  localparam int N_W   = 2 * R_W;
  localparam int REM_W = R_W + 2;
  localparam logic [WIN_BITS-1:0] WIN_LIMIT =
    (WINDOW_MAX > (2 ** WIN_BITS) - 1) ? WIN_BITS'((2 ** WIN_BITS) - 1)
                                       : WIN_BITS'(WINDOW_MAX);

  function automatic logic [SAMPLE_BITS-1:0] mag_sample(
    input logic [SAMPLE_BITS-1:0] v
  );
    return v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
  endfunction

  // configuration and history state
  logic [WIN_BITS-1:0]           w;
  logic [WIN_BITS-1:0]           fill;
  logic [PTR_W-1:0]              wp;
  logic signed [S1_W-1:0]        s1;
  logic [S2_W-1:0]               s2;

  // per-item registers
  logic [SAMPLE_BITS-1:0]        smp;
  logic [SAMPLE_BITS-1:0]        old;
  logic [2*SAMPLE_BITS-1:0]      smp_sq;
  logic [2*SAMPLE_BITS-1:0]      old_sq;
  logic [D_W-1:0]                prod_a;
  logic [D_W-1:0]                prod_b;

  // square root and divide
  logic [N_W-1:0]                n_sh;
  logic [REM_W-1:0]              rem;
  logic [R_W-1:0]                root;
  logic [R_W-1:0]                quo;
  logic [WIN_BITS-1:0]           drem;

  logic [PTR_W-1:0]              old_addr;
  logic [AW-1:0]                 wp_e;
  logic [AW-1:0]                 w_e;
  logic [AW-1:0]                 old_e;
  logic [SAMPLE_BITS-1:0]        ram_rdata;
  logic [SAMPLE_BITS-1:0]        smp_mag;
  logic [SAMPLE_BITS-1:0]        old_mag;
  logic [S1_W-1:0]               s1_mag;
  logic [2*S1_W-1:0]             s1_sq;
  logic [WIN_BITS+S2_W-1:0]      w_s2;
  logic [D_W-1:0]                diff;
  logic [REM_W+1:0]              rem_t;
  logic [REM_W+1:0]              trial;
  logic                          root_ge;
  logic [WIN_BITS:0]             div_t;
  logic                          div_ge;
  logic                          full_pre;
  logic [S1_W-1:0]               smp_ext;
  logic [S1_W-1:0]               old_ext;

  // evicted entry sits W places behind the write pointer
  assign wp_e     = AW'(wp);
  assign w_e      = AW'(w);
  assign old_e    = (wp_e >= w_e) ? (wp_e - w_e) : (wp_e + AW'(WINDOW_MAX) - w_e);
  assign old_addr = old_e[PTR_W-1:0];

  msd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_hist (
    .clk   (clk),
    .we    (cmd.load_old),
    .waddr (wp),
    .wdata (smp),
    .raddr (old_addr),
    .rdata (ram_rdata)
  );

  assign smp_mag = mag_sample(smp);
  assign old_mag = mag_sample(ram_rdata);
  assign s1_mag  = s1[S1_W-1] ? (~s1 + 1'b1) : s1;
  assign s1_sq   = s1_mag * s1_mag;
  assign w_s2    = w * s2;
  assign diff    = prod_a - prod_b;

  assign smp_ext  = {{(S1_W-SAMPLE_BITS){smp[SAMPLE_BITS-1]}}, smp};
  assign old_ext  = {{(S1_W-SAMPLE_BITS){old[SAMPLE_BITS-1]}}, old};
  assign full_pre = (fill >= w);

  // one root bit: bring down two bits, try root*4+1
  assign rem_t   = {rem, n_sh[N_W-1 -: 2]};
  assign trial   = {{(REM_W-R_W){1'b0}}, root, 2'b01};
  assign root_ge = (rem_t >= trial);

  // one quotient bit of root / W
  assign div_t  = {drem, quo[R_W-1]};
  assign div_ge = (div_t >= {1'b0, w});

  assign status.window_full = (fill >= w);
  assign status.out_busy    = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      w    <= WIN_BITS'(1);
      fill <= '0;
      wp   <= '0;
      s1   <= '0;
      s2   <= '0;
    end else if (cfg_we) begin
      w    <= (cfg_wdata == '0) ? WIN_BITS'(1)
            : ((cfg_wdata > WIN_LIMIT) ? WIN_LIMIT : cfg_wdata);
      fill <= '0;
      wp   <= '0;
      s1   <= '0;
      s2   <= '0;
    end else if (cmd.capture && in_data.start_series) begin
      fill <= '0;
      wp   <= '0;
      s1   <= '0;
      s2   <= '0;
    end else if (cmd.update) begin
      if (full_pre) begin
        s1 <= s1 + smp_ext - old_ext;
        s2 <= s2 + S2_W'(smp_sq) - S2_W'(old_sq);
      end else begin
        fill <= fill + 1'b1;
        s1   <= s1 + smp_ext;
        s2   <= s2 + S2_W'(smp_sq);
      end
      wp <= (wp == PTR_W'(WINDOW_MAX - 1)) ? '0 : wp + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      smp <= in_data.sample;
    end
    if (cmd.load_old) begin
      old    <= ram_rdata;
      old_sq <= old_mag * old_mag;
      smp_sq <= smp_mag * smp_mag;
    end
    if (cmd.mult) begin
      prod_a <= w_s2[D_W-1:0];
      prod_b <= s1_sq[D_W-1:0];
    end
    if (cmd.diff_load) begin
      n_sh <= N_W'(diff) << (2 * FRAC_BITS);
      rem  <= '0;
      root <= '0;
    end else if (cmd.sqrt_step) begin
      n_sh <= n_sh << 2;
      rem  <= root_ge ? REM_W'(rem_t - trial) : REM_W'(rem_t);
      root <= {root[R_W-2:0], root_ge};
    end
    if (cmd.div_load) begin
      quo  <= root;
      drem <= '0;
    end else if (cmd.div_step) begin
      drem <= div_ge ? WIN_BITS'(div_t - {1'b0, w}) : div_t[WIN_BITS-1:0];
      quo  <= {quo[R_W-2:0], div_ge};
    end
  end

  // output register: hold until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      out_data.deviation_valid <= status.window_full;
      if (!status.window_full) begin
        out_data.deviation <= '0;
      end else if (quo > R_W'({DEV_BITS{1'b1}})) begin
        out_data.deviation <= {DEV_BITS{1'b1}};
      end else begin
        out_data.deviation <= quo[DEV_BITS-1:0];
      end
    end
  end

endmodule

// ----- test/deviation_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deviation_checker - result predictor and comparator for the rolling deviation
// Watches the sample, result and window-register channels, keeps its own copy
// of the delay line and running sums, and compares every result in order.
// ----------------------------------------------------------------------------
module deviation_checker import msd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  in_item_t            in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [WIN_BITS-1:0] cfg_wdata,
  output int                  mismatches,
  output int                  pending
);

  localparam int          HISTORY_DEPTH = WINDOW_MAX_DEF;
  localparam int          FRAC          = FRAC_BITS_DEF;
  localparam logic [63:0] DEV_LIMIT     = (64'd1 << DEV_BITS) - 64'd1;
  localparam int          REPORT_LIMIT  = 10;

  int unsigned window;
  longint      history [HISTORY_DEPTH];
  longint      run_sum;
  longint      run_square_sum;
  int unsigned filled;
  int unsigned head;
  out_item_t   expected_devs [$];

  function automatic void clear_history();
    run_sum        = 0;
    run_square_sum = 0;
    filled         = 0;
    head           = 0;
  endfunction

  function automatic void set_window(input logic [WIN_BITS-1:0] value);
    if (value == 0) begin
      window = 1;
    end else if (value > HISTORY_DEPTH) begin
      window = HISTORY_DEPTH;
    end else begin
      window = value;
    end
    clear_history();
  endfunction

  function automatic logic [63:0] root_floor(input logic [127:0] radicand);
    logic [63:0]  root;
    logic [63:0]  trial;
    logic [127:0] trial_sq;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      trial    = root | (64'd1 << b);
      trial_sq = {64'd0, trial} * {64'd0, trial};
      if (trial_sq <= radicand) begin
        root = trial;
      end
    end
    return root;
  endfunction

  function automatic out_item_t predict_deviation(input in_item_t item);
    longint       s;
    longint       evicted;
    longint       spread;
    logic [127:0] radicand;
    logic [63:0]  dev;
    out_item_t    result;
    s = {{(64 - SAMPLE_BITS){item.sample[SAMPLE_BITS-1]}}, item.sample};
    if (item.start_series) begin
      clear_history();
    end
    // drop the oldest sample once the window is full
    if (filled >= window) begin
      evicted         = history[(head + HISTORY_DEPTH - window) % HISTORY_DEPTH];
      run_sum        -= evicted;
      run_square_sum -= evicted * evicted;
    end else begin
      filled++;
    end
    history[head]   = s;
    head            = (head + 1) % HISTORY_DEPTH;
    run_sum        += s;
    run_square_sum += s * s;
    result = '0;
    if (filled >= window) begin
      spread   = longint'(window) * run_square_sum - run_sum * run_sum;
      radicand = {64'd0, spread} << (2 * FRAC);
      dev      = root_floor(radicand) / window;
      result.deviation       = (dev > DEV_LIMIT) ? DEV_LIMIT[DEV_BITS-1:0] : dev[DEV_BITS-1:0];
      result.deviation_valid = 1'b1;
    end
    return result;
  endfunction

  function automatic void note_mismatch(input string what, input out_item_t want,
                                        input out_item_t got);
    if (mismatches < REPORT_LIMIT) begin
      $display("%0t ns %s: expected deviation=%0d valid=%0b, got deviation=%0d valid=%0b",
               $realtime, what, want.deviation, want.deviation_valid,
               got.deviation, got.deviation_valid);
    end
    mismatches++;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      window = 1;
      clear_history();
      expected_devs.delete();
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_devs.size() == 0) begin
          note_mismatch("result with nothing outstanding", '0, out_data);
        end else begin
          want = expected_devs.pop_front();
          if (out_data.deviation !== want.deviation ||
              out_data.deviation_valid !== want.deviation_valid) begin
            note_mismatch("deviation mismatch", want, out_data);
          end
        end
      end
      if (cfg_we) begin
        set_window(cfg_wdata);
      end
      if (in_valid && in_ready) begin
        expected_devs.insert(expected_devs.size(), predict_deviation(in_data));
      end
    end
    pending = expected_devs.size();
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - moving standard deviation top-level test
// Directed extremes and window edge cases, then random series over many
// window settings with bursty input, random output stalls and one long hold.
// ----------------------------------------------------------------------------
module testbench;
  import msd_pkg::*;

  localparam int ITEM_TARGET    = 2000;
  localparam int LONG_HOLD      = 800;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 200;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum int {ALWAYS_READY, COIN_FLIP, MOSTLY_STALLED, MOSTLY_READY} ready_style_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_we    = 1'b0;
  logic [WIN_BITS-1:0] cfg_wdata = '0;

  int mismatches;
  int pending;
  int sent_items   = 0;
  int burst_left   = 0;
  int idle_cycles  = 0;
  bit hold_request = 1'b0;

  moving_std_deviation uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  deviation_checker deviation_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // offer one sample, opening a new burst after a random gap when due
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value, input logic restart);
    in_item_t item;
    int       gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item.sample       = value;
    item.start_series = restart;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    sent_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(input logic [WIN_BITS-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] random_sample(
      input logic signed [SAMPLE_BITS-1:0] base);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      return SAMPLE_MAX;
    end else if (roll < 20) begin
      return SAMPLE_MIN;
    end else if (roll < 50) begin
      return SAMPLE_BITS'($urandom);
    end else if (roll < 75) begin
      // cluster around the series level for small spreads
      return SAMPLE_BITS'(base + $signed($urandom_range(0, 63)) - 32);
    end else if (roll < 90) begin
      return SAMPLE_BITS'($signed($urandom_range(0, 511)) - 256);
    end else begin
      return SAMPLE_BITS'(-$signed($urandom_range(0, 1)));
    end
  endfunction

  initial begin : stimulus
    int                            phase;
    int                            phase_items;
    int unsigned                   w_raw;
    int unsigned                   w_eff;
    logic signed [SAMPLE_BITS-1:0] base;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // window of one straight out of reset
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(0, 1'b0);
    send_sample(-1, 1'b0);

    // widest swing across a window of two, then a restart
    write_window(2);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(1, 1'b1);
    send_sample(0, 1'b0);
    send_sample(-1, 1'b0);

    // zero window reads as one
    write_window(0);
    send_sample(12345, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);

    // restart before the window fills
    write_window(3);
    send_sample(100, 1'b0);
    send_sample(-100, 1'b0);
    send_sample(7, 1'b1);
    send_sample(7, 1'b0);
    send_sample(7, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(0, 1'b0);

    phase = 0;
    while (sent_items < ITEM_TARGET) begin
      case (phase)
        0:       w_raw = 127;
        1:       w_raw = 64;
        2:       w_raw = 65;
        3:       w_raw = 0;
        4:       w_raw = 1;
        5:       w_raw = 2;
        default: w_raw = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(0, 127);
      endcase
      write_window(WIN_BITS'(w_raw));
      // long output hold while the biggest window runs
      if (phase == 0) begin
        hold_request = 1'b1;
      end
      w_eff       = (w_raw == 0) ? 1 : ((w_raw > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : w_raw);
      base        = SAMPLE_BITS'($urandom);
      phase_items = w_eff + $urandom_range(10, 100);
      repeat (phase_items) begin
        send_sample(random_sample(base), $urandom_range(0, 3 * w_eff + 30) == 0);
      end
      phase++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : receiver
    ready_style_t style;
    int           span;
    bit           held;
    held = 1'b0;
    forever begin
      style = ready_style_t'($urandom_range(0, 3));
      span  = $urandom_range(10, 200);
      repeat (span) begin
        @(posedge clk);
        case (style)
          ALWAYS_READY:   out_ready <= 1'b1;
          COIN_FLIP:      out_ready <= 1'($urandom_range(0, 1));
          MOSTLY_STALLED: out_ready <= ($urandom_range(0, 7) == 0);
          MOSTLY_READY:   out_ready <= ($urandom_range(0, 3) != 0);
          default:        out_ready <= 1'b1;
        endcase
      end
      if (hold_request && !held) begin
        held = 1'b1;
        @(posedge clk);
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
    end
  end

  // give up after a long stretch with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
